[sv/mqbf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqbf_pkg
// Shared types and fixed widths for the multi-queue byte FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package mqbf_pkg;

  // Fixed field widths
  localparam int SIZE_W        = 9;
  localparam int FILL_W        = 9;
  localparam int BYTE_W        = 8;
  localparam int OP_W          = 2;
  localparam int QID_W         = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int NUM_SIZE_REGS = 4;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } mqbf_op_t;

  // Request sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOKUP = 2'd1,
    ST_RESULT = 2'd2
  } mqbf_state_t;

  // Outcome flags of one queue update
  typedef struct packed {
    logic push_ok;
    logic read_hit;
  } mqbf_upd_flags_t;

endpackage

`default_nettype wire

[sv/mqbf_ptr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqbf_ptr_ram
// Per-queue pointer table: one write port, one registered read port. Entries
// never written since reset read back as the reset entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mqbf_ptr_ram #(
  parameter int DEPTH = 4,
  parameter int AW    = 2,
  parameter int EW    = 33,
  parameter logic [EW-1:0] RST_ENTRY = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [EW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [EW-1:0] wr_data
);

  logic [EW-1:0]    mem [DEPTH];
  logic [EW-1:0]    rd_raw_r;
  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;

  // Write entry and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_r <= mem[rd_addr];
    end
  end

  // Track written entries; sample the valid bit along with the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : RST_ENTRY;

endmodule

`default_nettype wire

[sv/mqbf_byte_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqbf_byte_ram
// Shared byte store for all queues: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mqbf_byte_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [mqbf_pkg::BYTE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [mqbf_pkg::BYTE_W-1:0] rd_data
);

  import mqbf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // Write byte and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/mqbf_queue_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqbf_queue_update
// Applies one request to a queue's pointer entry: advances the request's
// cursor (clear resets write/read), updates fill level, picks the byte slot.
// ----------------------------------------------------------------------------
`default_nettype none

module mqbf_queue_update #(
  parameter int PW = 8,
  parameter int SW = 9
) (
  input  mqbf_pkg::mqbf_op_t        op,
  input  logic [SW-1:0]             size,
  input  logic [PW-1:0]             wptr,
  input  logic [PW-1:0]             rptr,
  input  logic [PW-1:0]             lptr,
  input  logic [SW-1:0]             fill,
  output logic [PW-1:0]             new_wptr,
  output logic [PW-1:0]             new_rptr,
  output logic [PW-1:0]             new_lptr,
  output logic [SW-1:0]             new_fill,
  output logic [SW-1:0]             free,
  output logic [PW-1:0]             mem_ptr,
  output mqbf_pkg::mqbf_upd_flags_t flags
);

  import mqbf_pkg::*;

  logic [PW-1:0] top;

  // Increment and wrap at the queue size
  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [SW-1:0] s);
    logic [PW:0] n;
    begin
      n = {1'b0, p} + 1'b1;
      adv = (n >= (PW+1)'(s)) ? '0 : n[PW-1:0];
    end
  endfunction

  assign top = PW'(size - 1'b1);

  // Update the entry for the requested operation
  always_comb begin
    new_wptr = wptr;
    new_rptr = rptr;
    new_lptr = lptr;
    new_fill = fill;
    mem_ptr  = wptr;
    flags    = '0;
    unique case (op)
      OP_PUSH: begin
        if (fill < size) begin
          new_wptr      = adv(wptr, size);
          mem_ptr       = new_wptr;
          new_fill      = fill + 1'b1;
          flags.push_ok = 1'b1;
        end
      end
      OP_POP: begin
        if (fill != '0) begin
          new_rptr       = adv(rptr, size);
          mem_ptr        = new_rptr;
          new_fill       = fill - 1'b1;
          flags.read_hit = 1'b1;
        end
      end
      OP_PEEK: begin
        if (fill != '0) begin
          new_lptr       = adv(lptr, size);
          mem_ptr        = new_lptr;
          flags.read_hit = 1'b1;
        end
      end
      OP_CLEAR: begin
        new_wptr = top;
        new_rptr = top;
        new_fill = '0;
      end
    endcase
  end

  assign free = size - new_fill;

endmodule

`default_nettype wire

[sv/multi_queue_byte_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_byte_fifo
// Several byte ring queues with per-queue size, sharing one byte store.
//
// Input channel (in_valid/in_stall) carries a request: push, pop, peek
// (look-ahead cursor) or clear, plus queue id and push byte. Each request
// yields one transfer on the result channel (out_valid/out_stall) with the
// byte read, hit/accept flags and the queue's fill count and free space.
// Sequence: a request is taken in idle and its pointer entry is read at that
// edge; the next cycle updates the entry and accesses the byte store, and the
// result is loaded into the output register in the result state once it is
// free. Each request steps through idle, lookup and result, set by the
// pointer table read then the byte store read; a new one is taken only in idle.
// A waiting result holds the sequencer until the receiver lifts out_stall;
// in_stall stays high while a request is in flight.
// Config port: cfg_we writes size register cfg_index, which also resets that
// queue's pointers; write only while idle.
// Reset: size registers go to 256 and the pointer table valid bits clear, so
// every queue reads empty at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_byte_fifo #(
  parameter int NUM_QUEUES = 4,
  parameter int MAX_DEPTH  = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mqbf_pkg::OP_W-1:0]      in_req_type,
  input  logic [mqbf_pkg::QID_W-1:0]     in_queue_id,
  input  logic [mqbf_pkg::BYTE_W-1:0]    in_push_byte,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mqbf_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                           out_read_valid,
  output logic                           out_push_accepted,
  output logic [mqbf_pkg::FILL_W-1:0]    out_fill_count,
  output logic [mqbf_pkg::FILL_W-1:0]    out_free_space,
  // configuration
  input  logic                           cfg_we,
  input  logic [mqbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mqbf_pkg::SIZE_W-1:0]    cfg_data
);

  import mqbf_pkg::*;

  localparam int PW     = $clog2(MAX_DEPTH);
  localparam int SW     = $clog2(MAX_DEPTH + 1);
  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int EW     = 3 * PW + SW;
  localparam int BDEPTH = NUM_QUEUES * (1 << PW);
  localparam int BAW    = $clog2(BDEPTH);
  localparam logic [SIZE_W-1:0] MAX_SIZE   = SIZE_W'(MAX_DEPTH);
  localparam logic [SIZE_W-1:0] RST_SIZE   = SIZE_W'(256);
  localparam logic [2:0]        NQ         = 3'(NUM_QUEUES);
  localparam logic [PW-1:0]     RST_TOP    = PW'(MAX_DEPTH - 1);
  localparam logic [EW-1:0]     RST_ENTRY  = {RST_TOP, RST_TOP, RST_TOP, SW'(0)};

  // Size register to effective size: zero acts as one, clamp at max depth
  function automatic logic [SW-1:0] eff_size(input logic [SIZE_W-1:0] s);
    begin
      if (s == '0) begin
        eff_size = SW'(1);
      end else if (s > MAX_SIZE) begin
        eff_size = SW'(MAX_DEPTH);
      end else begin
        eff_size = SW'(s);
      end
    end
  endfunction

  mqbf_state_t state_r, state_nxt;

  logic              in_fire;
  logic              lookup_act;
  logic              out_free;
  logic              out_load;

  logic [SIZE_W-1:0] size_r [NUM_SIZE_REGS];

  mqbf_op_t          op_r;
  logic [QID_W-1:0]  q_r;
  logic              q_ok_r;
  logic [BYTE_W-1:0] byte_r;

  logic              push_ok_r;
  logic              read_hit_r;
  logic [SW-1:0]     fill_r;
  logic [SW-1:0]     free_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_read_byte_r;
  logic              out_read_valid_r;
  logic              out_push_accepted_r;
  logic [FILL_W-1:0] out_fill_count_r;
  logic [FILL_W-1:0] out_free_space_r;

  logic [EW-1:0]     ptr_rd_data;
  logic              ptr_wr_en;
  logic [QW-1:0]     ptr_wr_addr;
  logic [EW-1:0]     ptr_wr_data;
  logic              cfg_hit;
  logic [PW-1:0]     cfg_top;

  logic [SW-1:0]     eff_q;
  logic [PW-1:0]     cur_w, cur_r, cur_l;
  logic [SW-1:0]     cur_fill;
  logic [PW-1:0]     upd_w, upd_r, upd_l, upd_ptr;
  logic [SW-1:0]     upd_fill, upd_free;
  mqbf_upd_flags_t   upd_flags;

  logic              byte_wr_en;
  logic              byte_rd_en;
  logic [BAW-1:0]    byte_addr;
  logic [BYTE_W-1:0] byte_rd_data;

  assign in_fire = in_valid && !in_stall;

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_RESULT;
      ST_RESULT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall   = 1'b1;
    lookup_act = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall   = 1'b0;
      ST_LOOKUP: lookup_act = 1'b1;
      ST_RESULT: out_load   = out_free;
      default:   in_stall   = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SIZE_REGS; i++) begin
        size_r[i] <= RST_SIZE;
      end
    end else if (cfg_we) begin
      size_r[cfg_index] <= cfg_data;
    end
  end

  // Capture the request on transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= mqbf_op_t'(in_req_type);
      q_r    <= in_queue_id;
      q_ok_r <= ({1'b0, in_queue_id} < NQ);
      byte_r <= in_push_byte;
    end
  end

  // Pointer table write: config reinit first (user: idle only), else write-back
  assign cfg_hit = cfg_we && ({1'b0, cfg_index} < NQ);
  assign cfg_top = PW'(eff_size(cfg_data) - 1'b1);

  always_comb begin
    ptr_wr_en   = 1'b0;
    ptr_wr_addr = q_r[QW-1:0];
    ptr_wr_data = {upd_w, upd_r, upd_l, upd_fill};
    priority if (cfg_hit) begin
      ptr_wr_en   = 1'b1;
      ptr_wr_addr = cfg_index[QW-1:0];
      ptr_wr_data = {cfg_top, cfg_top, cfg_top, SW'(0)};
    end else if (lookup_act && q_ok_r) begin
      ptr_wr_en   = 1'b1;
    end
  end

  mqbf_ptr_ram #(
    .DEPTH     (NUM_QUEUES),
    .AW        (QW),
    .EW        (EW),
    .RST_ENTRY (RST_ENTRY)
  ) u_ptr_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (in_queue_id[QW-1:0]),
    .rd_data (ptr_rd_data),
    .wr_en   (ptr_wr_en),
    .wr_addr (ptr_wr_addr),
    .wr_data (ptr_wr_data)
  );

  // Unpack the entry and apply the request
  assign {cur_w, cur_r, cur_l, cur_fill} = ptr_rd_data;
  assign eff_q = eff_size(size_r[q_r]);

  mqbf_queue_update #(
    .PW (PW),
    .SW (SW)
  ) u_update (
    .op       (op_r),
    .size     (eff_q),
    .wptr     (cur_w),
    .rptr     (cur_r),
    .lptr     (cur_l),
    .fill     (cur_fill),
    .new_wptr (upd_w),
    .new_rptr (upd_r),
    .new_lptr (upd_l),
    .new_fill (upd_fill),
    .free     (upd_free),
    .mem_ptr  (upd_ptr),
    .flags    (upd_flags)
  );

  // Byte store access in the lookup cycle
  assign byte_addr  = BAW'({q_r[QW-1:0], upd_ptr});
  assign byte_wr_en = lookup_act && q_ok_r && upd_flags.push_ok;
  assign byte_rd_en = lookup_act && q_ok_r && upd_flags.read_hit;

  mqbf_byte_ram #(
    .DEPTH (BDEPTH),
    .AW    (BAW)
  ) u_byte_ram (
    .clk     (clk),
    .wr_en   (byte_wr_en),
    .wr_addr (byte_addr),
    .wr_data (byte_r),
    .rd_en   (byte_rd_en),
    .rd_addr (byte_addr),
    .rd_data (byte_rd_data)
  );

  // Hold status of the update for the result stage
  always_ff @(posedge clk) begin
    if (lookup_act) begin
      push_ok_r  <= q_ok_r && upd_flags.push_ok;
      read_hit_r <= q_ok_r && upd_flags.read_hit;
      fill_r     <= q_ok_r ? upd_fill : '0;
      free_r     <= q_ok_r ? upd_free : '0;
    end
  end

  // Output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_read_byte_r     <= read_hit_r ? byte_rd_data : '0;
      out_read_valid_r    <= read_hit_r;
      out_push_accepted_r <= push_ok_r;
      out_fill_count_r    <= FILL_W'(fill_r);
      out_free_space_r    <= FILL_W'(free_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_byte     = out_read_byte_r;
  assign out_read_valid    = out_read_valid_r;
  assign out_push_accepted = out_push_accepted_r;
  assign out_fill_count    = out_fill_count_r;
  assign out_free_space    = out_free_space_r;

  // Checks
  a_lookup_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_LOOKUP))
    else $error("request transfer not followed by pointer lookup");

  a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result appeared without a finished request");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_read_valid_r && out_push_accepted_r))
    else $error("read hit and push accept in one result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((10'(out_fill_count_r) + 10'(out_free_space_r)) <= 10'(MAX_DEPTH)))
    else $error("fill count plus free space exceeds depth");

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-queue byte FIFO.
//
// A short table of requests with hand-worked results covers empty reads,
// full drops, stale and wrapping look-ahead reads, clear, and out-of-range
// sizes. Random phases follow, each with fresh queue sizes. A local queue
// model predicts every result. Both channels idle at random, except for one
// long calm phase. Results are compared in order, field by field.
// ----------------------------------------------------------------------------

module tb;
  import mqbf_pkg::*;

  localparam int NQ          = 4;
  localparam int DEPTH       = 256;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 100;
  localparam int IDLE_PCT    = 11;
  localparam int SIZE_REG0   = 0;
  // Room for 625 requests even with both sides idling
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic              push_accepted;
    logic [FILL_W-1:0] fill_count;
    logic [FILL_W-1:0] free_space;
  } queue_result_t;

  typedef struct packed {
    mqbf_op_t          op;
    logic [QID_W-1:0]  qid;
    logic [BYTE_W-1:0] data;
    queue_result_t     res;
  } request_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_req_type;
  logic [QID_W-1:0]     in_queue_id;
  logic [BYTE_W-1:0]    in_push_byte;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_read_byte;
  logic                 out_read_valid;
  logic                 out_push_accepted;
  logic [FILL_W-1:0]    out_fill_count;
  logic [FILL_W-1:0]    out_free_space;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  // Queue model state
  logic [SIZE_W-1:0] size_regs    [NQ];
  logic [BYTE_W-1:0] byte_mem     [NQ][DEPTH];
  bit                byte_written [NQ][DEPTH];
  logic [7:0]        wr_ptr       [NQ];
  logic [7:0]        rd_ptr       [NQ];
  logic [7:0]        look_ptr     [NQ];
  logic [FILL_W-1:0] fill_lvl     [NQ];

  queue_result_t expected_results [$];
  request_row_t  dir_rows [$];
  int            mismatches = 0;
  bit            calm = 1'b0;

  multi_queue_byte_fifo u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_queue_id       (in_queue_id),
    .in_push_byte      (in_push_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_byte     (out_read_byte),
    .out_read_valid    (out_read_valid),
    .out_push_accepted (out_push_accepted),
    .out_fill_count    (out_fill_count),
    .out_free_space    (out_free_space),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #10 clk = ~clk;

  // Effective capacity: zero acts as one, anything above the depth as the depth
  function automatic int eff_size(int q);
    if (size_regs[q] == '0) return 1;
    if (size_regs[q] > DEPTH) return DEPTH;
    return int'(size_regs[q]);
  endfunction

  function automatic logic [7:0] step_ptr(logic [7:0] p, int s);
    int n;
    n = int'(p) + 1;
    return 8'((n >= s) ? 0 : n);
  endfunction

  function automatic void init_queue(int q);
    logic [7:0] top;
    top = 8'(eff_size(q) - 1);
    wr_ptr[q]   = top;
    rd_ptr[q]   = top;
    look_ptr[q] = top;
    fill_lvl[q] = '0;
  endfunction

  function automatic void model_reset();
    for (int q = 0; q < NQ; q++) begin
      size_regs[q] = SIZE_W'(DEPTH);
      init_queue(q);
      for (int i = 0; i < DEPTH; i++) byte_written[q][i] = 1'b0;
    end
  endfunction

  // Update the queue model for one request and return its result
  function automatic queue_result_t apply_request(mqbf_op_t op, int q, logic [7:0] b);
    queue_result_t r;
    int s;
    r = '0;
    s = eff_size(q);
    case (op)
      OP_PUSH: begin
        if (fill_lvl[q] < s) begin
          wr_ptr[q] = step_ptr(wr_ptr[q], s);
          byte_mem[q][wr_ptr[q]] = b;
          byte_written[q][wr_ptr[q]] = 1'b1;
          fill_lvl[q] = fill_lvl[q] + 1'b1;
          r.push_accepted = 1'b1;
        end
      end
      OP_POP: begin
        if (fill_lvl[q] != 0) begin
          rd_ptr[q] = step_ptr(rd_ptr[q], s);
          fill_lvl[q] = fill_lvl[q] - 1'b1;
          r.read_byte = byte_mem[q][rd_ptr[q]];
          r.read_valid = 1'b1;
        end
      end
      OP_PEEK: begin
        if (fill_lvl[q] != 0) begin
          look_ptr[q] = step_ptr(look_ptr[q], s);
          r.read_byte = byte_mem[q][look_ptr[q]];
          r.read_valid = 1'b1;
        end
      end
      default: begin
        // look-ahead cursor stays where it is
        wr_ptr[q]   = 8'(s - 1);
        rd_ptr[q]   = 8'(s - 1);
        fill_lvl[q] = '0;
      end
    endcase
    r.fill_count = fill_lvl[q];
    r.free_space = FILL_W'(s) - fill_lvl[q];
    return r;
  endfunction

  // The look-ahead cursor ignores the fill count; keep it off never-written bytes
  function automatic bit peek_hits_unwritten(int q);
    if (fill_lvl[q] == 0) return 1'b0;
    return !byte_written[q][step_ptr(look_ptr[q], eff_size(q))];
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll <= 5) return SIZE_W'($urandom_range(1, 8));
    if (roll == 6) return SIZE_W'($urandom_range(9, 255));
    if (roll == 7) return SIZE_W'(DEPTH);
    if (roll == 8) return '0;
    return SIZE_W'($urandom_range(257, 511));
  endfunction

  function automatic void add_row(mqbf_op_t op, int q, int b, int rb, int rv, int pa,
                                  int fc, int fs);
    request_row_t row;
    row.op                = op;
    row.qid               = QID_W'(q);
    row.data              = BYTE_W'(b);
    row.res.read_byte     = BYTE_W'(rb);
    row.res.read_valid    = rv[0];
    row.res.push_accepted = pa[0];
    row.res.fill_count    = FILL_W'(fc);
    row.res.free_space    = FILL_W'(fs);
    dir_rows.push_back(row);
  endfunction

  // Offer one request, hold it until the transfer, then log its result
  task automatic issue_request(input mqbf_op_t op, input logic [QID_W-1:0] q,
                               input logic [BYTE_W-1:0] b, input bit typed,
                               input queue_result_t typed_res);
    queue_result_t r;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= op;
    in_queue_id  <= q;
    in_push_byte <= b;
    do @(posedge clk); while (in_stall);
    r = apply_request(op, int'(q), b);
    expected_results.push_back(typed ? typed_res : r);
  endtask

  task automatic run_rows();
    for (int i = 0; i < dir_rows.size(); i++) begin
      issue_request(dir_rows[i].op, dir_rows[i].qid, dir_rows[i].data, 1'b1, dir_rows[i].res);
    end
    dir_rows.delete();
  endtask

  // Hold off requests until every outstanding result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Write all four size registers; each write reinitializes its queue
  task automatic write_sizes(input logic [SIZE_W-1:0] s0, input logic [SIZE_W-1:0] s1,
                             input logic [SIZE_W-1:0] s2, input logic [SIZE_W-1:0] s3);
    logic [SIZE_W-1:0] vals [NQ];
    vals[0] = s0;
    vals[1] = s1;
    vals[2] = s2;
    vals[3] = s3;
    for (int i = 0; i < NQ; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(SIZE_REG0 + i);
      cfg_data  <= vals[i];
      @(posedge clk);
      size_regs[i] = vals[i];
      init_queue(i);
    end
    cfg_we <= 1'b0;
  endtask

  // Stall the result channel at random and check each result transfer
  always @(posedge clk) begin
    queue_result_t want;
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %02h hit %0d pushed %0d fill %0d free %0d",
                   out_read_byte, out_read_valid, out_push_accepted, out_fill_count,
                   out_free_space);
      end else begin
        want = expected_results.pop_front();
        if (out_read_byte !== want.read_byte || out_read_valid !== want.read_valid ||
            out_push_accepted !== want.push_accepted ||
            out_fill_count !== want.fill_count || out_free_space !== want.free_space) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected byte %02h hit %0d pushed %0d fill %0d free %0d",
                     want.read_byte, want.read_valid, want.push_accepted,
                     want.fill_count, want.free_space);
            $display("          actual   byte %02h hit %0d pushed %0d fill %0d free %0d",
                     out_read_byte, out_read_valid, out_push_accepted, out_fill_count,
                     out_free_space);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    mqbf_op_t          op;
    logic [QID_W-1:0]  q;
    logic [BYTE_W-1:0] b;
    int                roll;
    int                push_end;
    int                pop_end;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = OP_PUSH;
    in_queue_id  = '0;
    in_push_byte = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    model_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset sizes: empty reads, stale and fresh look-ahead reads
    add_row(OP_POP,  0, 'h00, 'h00, 0, 0, 0, 256);
    add_row(OP_PEEK, 1, 'h00, 'h00, 0, 0, 0, 256);
    add_row(OP_PUSH, 0, 'hFF, 'h00, 0, 1, 1, 255);
    add_row(OP_PUSH, 0, 'h00, 'h00, 0, 1, 2, 254);
    add_row(OP_PEEK, 0, 'h00, 'hFF, 1, 0, 2, 254);
    add_row(OP_POP,  0, 'h00, 'hFF, 1, 0, 1, 255);
    add_row(OP_POP,  0, 'h00, 'h00, 1, 0, 0, 256);
    add_row(OP_PUSH, 0, 'h5A, 'h00, 0, 1, 1, 255);
    add_row(OP_PEEK, 0, 'h00, 'h00, 1, 0, 1, 255);
    add_row(OP_PEEK, 0, 'h00, 'h5A, 1, 0, 1, 255);
    @(posedge clk);
    run_rows();
    drain_results();

    // Tiny and out-of-range sizes: full drops, cursor wrap, clear keeps cursor
    write_sizes(9'd1, 9'd2, 9'd0, 9'd300);
    add_row(OP_PUSH,  0, 'h11, 'h00, 0, 1, 1, 0);
    add_row(OP_PUSH,  0, 'h22, 'h00, 0, 0, 1, 0);
    add_row(OP_POP,   0, 'h00, 'h11, 1, 0, 0, 1);
    add_row(OP_PUSH,  2, 'h80, 'h00, 0, 1, 1, 0);
    add_row(OP_PUSH,  2, 'h81, 'h00, 0, 0, 1, 0);
    add_row(OP_PUSH,  3, 'h01, 'h00, 0, 1, 1, 255);
    add_row(OP_PUSH,  1, 'h7F, 'h00, 0, 1, 1, 1);
    add_row(OP_PUSH,  1, 'hFE, 'h00, 0, 1, 2, 0);
    add_row(OP_PEEK,  1, 'h00, 'h7F, 1, 0, 2, 0);
    add_row(OP_PEEK,  1, 'h00, 'hFE, 1, 0, 2, 0);
    add_row(OP_PEEK,  1, 'h00, 'h7F, 1, 0, 2, 0);
    add_row(OP_CLEAR, 1, 'h00, 'h00, 0, 0, 0, 2);
    add_row(OP_PUSH,  1, 'h44, 'h00, 0, 1, 1, 1);
    add_row(OP_PEEK,  1, 'h00, 'hFE, 1, 0, 1, 1);
    add_row(OP_POP,   1, 'h00, 'h44, 1, 0, 0, 2);
    run_rows();
    drain_results();

    // Random phases, alternating push-heavy and pop-heavy mixes
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) write_sizes(9'd3, 9'd256, 9'd5, 9'd511);
      else write_sizes(pick_size(), pick_size(), pick_size(), pick_size());
      calm = (ph == 2);
      push_end = (ph % 2 == 0) ? 55 : 35;
      pop_end  = (ph % 2 == 0) ? 80 : 75;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) drain_results();
        q    = QID_W'($urandom_range(0, NQ - 1));
        b    = BYTE_W'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < push_end) op = OP_PUSH;
        else if (roll < pop_end) op = OP_POP;
        else if (roll < 95) op = OP_PEEK;
        else op = OP_CLEAR;
        if (op == OP_PEEK && peek_hits_unwritten(int'(q))) op = OP_PUSH;
        issue_request(op, q, b, 1'b0, '0);
      end
      drain_results();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
